// ===== src/tsrr_pkg.sv =====
`timescale 1ns / 1ps

package tsrr_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int LABEL_W    = 3;
  localparam int TIME_W     = 48;
  localparam int CHUNK_W    = 16;
  localparam int WIN_W      = 9;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int DIV_CNT_W  = $clog2(TIME_W + 1);

  localparam logic [LABEL_W-1:0] LABEL_EMPTY = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET  = 16'd16;
  localparam logic [WIN_W-1:0]   WINDOW_RESET = 9'd64;

  typedef enum logic [2:0] {
    MODE_CHECK     = 3'd0,
    MODE_MARK      = 3'd1,
    MODE_ADVANCE   = 3'd2,
    MODE_OCCUPANCY = 3'd3,
    MODE_CLEAR     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ORDER    = 2'd1,
    ERR_BACKWARD = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_STEPS,
    ST_WAIT_STEPS,
    ST_DIV_BASE,
    ST_WAIT_BASE,
    ST_INIT,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic div_start;
    logic div_sel;      // 0: elapsed time, 1: target time
    logic latch_steps;
    logic latch_base;
    logic walk_init;
    logic walk_step;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  err;
    logic  div_done;
    logic  walk_done;
  } ctrl_sts_t;

endpackage

// ===== src/time_slot_reservation_ring_core.sv =====
`timescale 1ns / 1ps

// Time-slot reservation ring: 256 three-bit slot labels (0 = empty) viewed
// through a moving base. Each input word carries a mode: check (does a region
// starting at a relative slot fit before the ring end and hold one label),
// mark (write a label over the range first..last, error 1 if first > last),
// advance (move to a target time, emptying the slots that pass; error 2 if
// time goes backward), occupancy (count non-empty slots in the window) and
// clear. Every input word yields exactly one result word. Words are worked
// one at a time: check, mark and occupancy walk the n slots that they touch,
// since the label RAM has a single port and is walked one slot per cycle.
// Advance adds two passes through a one-bit-per-cycle 48-bit divider before
// clearing up to 256 slots. Clear walks no slots; the ring is emptied through
// per-slot valid flops, so there is no clearing pass after reset. A finished
// result sits in the output register while the next word is accepted.
// Configuration (chunk_length at index 0, window_length at index 1) may be
// written only while the block is idle.

module time_slot_reservation_ring_core import tsrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            mode,
  input  logic [ADDR_W-1:0]     first_slot,
  input  logic [ADDR_W-1:0]     last_slot,
  input  logic [ADDR_W-1:0]     region_length,
  input  logic [LABEL_W-1:0]    slot_label,
  input  logic [TIME_W-1:0]     target_time,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  region_ok,
  output logic [1:0]            error_code,
  output logic [CNT_W-1:0]      occupied_count,
  output logic [TIME_W-1:0]     current_base_time
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: decode, divider phases, slot walk, result hand-off
  tsrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // label RAM, ring base, base time, divider and result registers
  tsrr_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .first_slot        (first_slot),
    .last_slot         (last_slot),
    .region_length     (region_length),
    .slot_label        (slot_label),
    .target_time       (target_time),
    .cmd               (cmd),
    .sts               (sts),
    .region_ok         (region_ok),
    .error_code        (error_code),
    .occupied_count    (occupied_count),
    .current_base_time (current_base_time)
  );

endmodule

// ===== src/tsrr_ram.sv =====
`timescale 1ns / 1ps

module tsrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/tsrr_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tsrr_div import tsrr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  input  logic [CHUNK_W-1:0] divisor,
  output logic               done,
  output logic [TIME_W-1:0]  quo,
  output logic [CHUNK_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [CHUNK_W:0]     rem_sh;
  logic [CHUNK_W:0]     rem_sub;
  logic                 ge;

  assign rem_sh  = {rem, quo[TIME_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[TIME_W-2:0], ge};
      rem <= ge ? rem_sub[CHUNK_W-1:0] : rem_sh[CHUNK_W-1:0];
    end
  end

endmodule

// ===== src/tsrr_dp.sv =====
`timescale 1ns / 1ps

module tsrr_dp import tsrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [2:0]            mode,
  input  logic [ADDR_W-1:0]     first_slot,
  input  logic [ADDR_W-1:0]     last_slot,
  input  logic [ADDR_W-1:0]     region_length,
  input  logic [LABEL_W-1:0]    slot_label,
  input  logic [TIME_W-1:0]     target_time,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  output logic                  region_ok,
  output logic [1:0]            error_code,
  output logic [CNT_W-1:0]      occupied_count,
  output logic [TIME_W-1:0]     current_base_time
);

  // config
  logic [CHUNK_W-1:0] chunk_length;
  logic [WIN_W-1:0]   window_length;

  // latched word
  mode_t              mode_q;
  logic [ADDR_W-1:0]  first_q;
  logic [ADDR_W-1:0]  last_q;
  logic [ADDR_W-1:0]  len_q;
  logic [LABEL_W-1:0] label_q;
  logic [TIME_W-1:0]  target_q;
  err_t               err;

  // ring state
  logic [ADDR_W-1:0]     ring_base;
  logic [TIME_W-1:0]     base_time;
  logic [SLOT_COUNT-1:0] vld;

  // advance results
  logic              steps_hi;
  logic [ADDR_W-1:0] steps_lo;
  logic [TIME_W-1:0] new_base_time;

  // walker
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  walk_n;
  logic [ADDR_W-1:0] walk_start;
  logic              ok_flag;
  logic [CNT_W-1:0]  occ_cnt;
  logic              rd_q;
  logic              vld_q;

  logic [CNT_W-1:0]   n_calc;
  logic [ADDR_W-1:0]  start_calc;
  logic [CNT_W-1:0]   end_sum;
  logic               ovf;
  logic [ADDR_W-1:0]  addr;
  logic               is_write;
  logic               ram_we;
  logic [LABEL_W-1:0] wdata;
  logic [LABEL_W-1:0] rdata;
  logic [LABEL_W-1:0] eff;
  mode_t              mode_in;
  err_t               err_in;

  logic [CHUNK_W-1:0] divisor;
  logic [TIME_W-1:0]  dividend;
  logic               div_done;
  logic [TIME_W-1:0]  div_quo;
  logic [CHUNK_W-1:0] div_rem;

  assign mode_in = mode_t'(mode);

  always_comb begin
    err_in = ERR_NONE;
    if (mode_in == MODE_MARK && first_slot > last_slot) begin
      err_in = ERR_ORDER;
    end else if (mode_in == MODE_ADVANCE && target_time < base_time) begin
      err_in = ERR_BACKWARD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_length  <= CHUNK_RESET;
      window_length <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK_LENGTH: begin
          chunk_length <= cfg_data[CHUNK_W-1:0];
        end
        CFG_WINDOW_LENGTH: begin
          window_length <= cfg_data[WIN_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode_in;
      first_q  <= first_slot;
      last_q   <= last_slot;
      len_q    <= region_length;
      label_q  <= slot_label;
      target_q <= target_time;
      err      <= err_in;
    end
  end

  // divider: elapsed slots first, then the target's remainder
  assign divisor  = (chunk_length == '0) ? CHUNK_W'(1) : chunk_length;
  assign dividend = cmd.div_sel ? target_q : (target_q - base_time);

  tsrr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_steps) begin
      steps_hi <= |div_quo[TIME_W-1:ADDR_W];
      steps_lo <= div_quo[ADDR_W-1:0];
    end
    if (cmd.latch_base) begin
      new_base_time <= target_q - {{(TIME_W-CHUNK_W){1'b0}}, div_rem};
    end
  end

  // walk length and start per mode
  assign end_sum = {1'b0, first_q} + {1'b0, len_q};
  assign ovf     = (len_q != '0) && (end_sum > CNT_W'(SLOT_COUNT));

  always_comb begin
    n_calc     = '0;
    start_calc = '0;
    case (mode_q)
      MODE_CHECK: begin
        n_calc     = ovf ? '0 : {1'b0, len_q};
        start_calc = first_q;
      end
      MODE_MARK: begin
        n_calc     = (err != ERR_NONE) ? '0 : ({1'b0, last_q} - {1'b0, first_q} + 1'b1);
        start_calc = first_q;
      end
      MODE_ADVANCE: begin
        if (err != ERR_NONE) begin
          n_calc = '0;
        end else begin
          n_calc = steps_hi ? CNT_W'(SLOT_COUNT) : {1'b0, steps_lo};
        end
      end
      MODE_OCCUPANCY: begin
        n_calc = (window_length > WIN_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                      : CNT_W'(window_length);
      end
      default: begin
        n_calc = '0;
      end
    endcase
  end

  assign addr     = ring_base + walk_start + cnt[ADDR_W-1:0];
  assign is_write = (mode_q == MODE_MARK) || (mode_q == MODE_ADVANCE);
  assign ram_we   = cmd.walk_step && is_write;
  assign wdata    = (mode_q == MODE_MARK) ? label_q : LABEL_EMPTY;

  tsrr_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // never-written slots read as empty
  assign eff = vld_q ? rdata : LABEL_EMPTY;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clear_all) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      walk_n  <= '0;
      rd_q    <= 1'b0;
      ok_flag <= 1'b0;
      occ_cnt <= '0;
    end else begin
      rd_q <= cmd.walk_step && !is_write;
      if (cmd.walk_init) begin
        cnt        <= '0;
        walk_n     <= n_calc;
        walk_start <= start_calc;
        ok_flag    <= !ovf;
        occ_cnt    <= '0;
      end else begin
        if (cmd.walk_step) begin
          cnt <= cnt + 1'b1;
        end
        if (rd_q) begin
          if (mode_q == MODE_CHECK && eff != label_q) begin
            ok_flag <= 1'b0;
          end
          if (mode_q == MODE_OCCUPANCY && eff != LABEL_EMPTY) begin
            occ_cnt <= occ_cnt + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
      base_time <= '0;
    end else if (cmd.clear_all) begin
      ring_base <= '0;
      base_time <= '0;
    end else if (cmd.commit && mode_q == MODE_ADVANCE && err == ERR_NONE) begin
      ring_base <= ring_base + steps_lo;
      base_time <= new_base_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      region_ok         <= (mode_q == MODE_CHECK) && ok_flag;
      error_code        <= err;
      occupied_count    <= (mode_q == MODE_OCCUPANCY) ? occ_cnt : '0;
      current_base_time <= base_time;
    end
  end

  assign sts.mode      = mode_q;
  assign sts.err       = (err != ERR_NONE);
  assign sts.div_done  = div_done;
  assign sts.walk_done = (cnt == walk_n);

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (rst) cnt <= walk_n)
    else $error("walk counter ran past its length");

  a_write_mode: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((mode_q == MODE_MARK) || (mode_q == MODE_ADVANCE)) && (err == ERR_NONE))
    else $error("slot write outside an error-free mark or advance");
`endif

endmodule

// ===== src/tsrr_ctrl.sv =====
`timescale 1ns / 1ps

module tsrr_ctrl import tsrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.mode == MODE_ADVANCE && !sts.err) begin
          state_next = ST_DIV_STEPS;
        end else if (sts.mode == MODE_CLEAR) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_INIT;
        end
      end
      ST_DIV_STEPS: begin
        state_next = ST_WAIT_STEPS;
      end
      ST_WAIT_STEPS: begin
        if (sts.div_done) state_next = ST_DIV_BASE;
      end
      ST_DIV_BASE: begin
        state_next = ST_WAIT_BASE;
      end
      ST_WAIT_BASE: begin
        if (sts.div_done) state_next = ST_INIT;
      end
      ST_INIT: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.walk_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        cmd.clear_all = (sts.mode == MODE_CLEAR);
      end
      ST_DIV_STEPS: begin
        cmd.div_start = 1'b1;
      end
      ST_WAIT_STEPS: begin
        cmd.latch_steps = sts.div_done;
      end
      ST_DIV_BASE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      ST_WAIT_BASE: begin
        cmd.div_sel    = 1'b1;
        cmd.latch_base = sts.div_done;
      end
      ST_INIT: begin
        cmd.walk_init = 1'b1;
      end
      ST_WALK: begin
        cmd.walk_step = !sts.walk_done;
      end
      ST_DRAIN: begin
        cmd.commit = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == ST_WAIT_STEPS || state == ST_WAIT_BASE))
    else $error("divider finished outside a wait state");
`endif

endmodule
